@@ design/bba_pkg.sv @@
package bba_pkg;

  localparam int unsigned Units  = 64;
  localparam int unsigned TopLvl = 6;
  localparam int unsigned NodeW  = 7;
  localparam int unsigned Depth  = 2 * Units;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT = 2'd1;
  localparam logic [1:0] STATUS_BAD    = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SPLIT,
    ST_FCHK,
    ST_MERGE,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [NodeW-1:0] rd_addr;
    logic             free_we;
    logic [NodeW-1:0] free_wa;
    logic             free_wd;
    logic             alloc_we;
    logic [NodeW-1:0] alloc_wa;
    logic             alloc_wd;
  } mem_req_t;

  // Index of the leading one: tree depth of a heap-ordered node.
  function automatic logic [2:0] node_depth(input logic [NodeW-1:0] n);
    logic [2:0] d;
    d = 3'd0;
    for (int i = 0; i < NodeW; i++) begin
      if (n[i]) d = 3'(i);
    end
    return d;
  endfunction

  function automatic logic [2:0] node_lvl(input logic [NodeW-1:0] n);
    return 3'(TopLvl) - node_depth(n);
  endfunction

  function automatic logic [5:0] node_off(input logic [NodeW-1:0] n);
    logic [NodeW-1:0] m;
    m = n & ~(7'd1 << node_depth(n));
    return 6'(m << node_lvl(n));
  endfunction

  // Smallest k with 2^k >= d, for d >= 1.
  function automatic logic [2:0] ceil_lg(input logic [6:0] d);
    logic [6:0] dm1;
    logic [2:0] k;
    dm1 = d - 7'd1;
    k   = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (dm1[i]) k = 3'(i + 1);
    end
    return k;
  endfunction

  function automatic logic [5:0] size_mask(input logic [2:0] s);
    return 6'((7'd1 << s) - 7'd1);
  endfunction

endpackage

@@ design/buddy_block_allocator.sv @@
// Buddy allocator over 64 units, the block tree held as free and granted marks in two
// one-bit RAMs of 128 nodes. After reset a clearing pass over all nodes runs with busy_o
// high. An allocate request scans all 127 nodes, one RAM read per cycle, then splits
// down one tree level per cycle. A free request checks that the block is granted, then
// absorbs free buddies one level at a time and marks the merged block free. A free that
// fails the size or alignment check, or a demand above the pool, is answered straight
// from idle, and a free of a block that is not granted once its granted mark is read.
// Each request yields exactly one result on done_o for one cycle; the receiver cannot
// stall it, and a new request may start in that cycle.
module buddy_block_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic       op_i,
  input  logic [6:0] demand_units_i,
  input  logic [5:0] free_offset_i,
  input  logic [2:0] free_size_log2_i,
  output logic       done_o,
  output logic [1:0] status_o,
  output logic [5:0] block_offset_o,
  output logic [2:0] block_size_log2_o
);
  import bba_pkg::*;

  state_e           state_q, state_d;
  logic [NodeW-1:0] cnt_q, cnt_d;
  logic             chk_v_q, chk_v_d;
  logic [NodeW-1:0] chk_n_q, chk_n_d;
  logic             best_v_q, best_v_d;
  logic [NodeW-1:0] best_n_q, best_n_d;
  logic [5:0]       best_off_q, best_off_d;
  logic [2:0]       k_q, k_d;
  logic [NodeW-1:0] cur_q, cur_d;
  logic [5:0]       off_q, off_d;
  logic [2:0]       s_q, s_d;
  logic             done_q, done_d;
  logic [1:0]       status_q, status_d;
  logic [5:0]       res_off_q, res_off_d;
  logic [2:0]       res_size_q, res_size_d;

  mem_req_t         mreq;
  logic             free_rd;
  logic             alloc_rd;

  logic             accept;
  logic [6:0]       dem;
  logic             free_bad;
  logic [NodeW-1:0] free_node;
  logic             hit;
  logic [NodeW-1:0] nxt;

  bba_tree u_tree (
    .clk_i      (clk_i),
    .req_i      (mreq),
    .free_rd_o  (free_rd),
    .alloc_rd_o (alloc_rd)
  );

  assign accept    = start_i && (state_q == ST_IDLE);
  assign dem       = (demand_units_i == 7'd0) ? 7'd1 : demand_units_i;
  assign free_bad  = (free_size_log2_i > 3'(TopLvl)) ||
                     ((free_offset_i & size_mask(free_size_log2_i)) != 6'd0);
  assign free_node = (7'd1 << (3'(TopLvl) - free_size_log2_i)) +
                     7'(free_offset_i >> free_size_log2_i);
  assign hit       = chk_v_q && free_rd && (node_lvl(chk_n_q) >= k_q) &&
                     (!best_v_q || (node_off(chk_n_q) < best_off_q));
  assign nxt       = cur_q >> 1;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    chk_v_d    = 1'b0;
    chk_n_d    = chk_n_q;
    best_v_d   = best_v_q;
    best_n_d   = best_n_q;
    best_off_d = best_off_q;
    k_d        = k_q;
    cur_d      = cur_q;
    off_d      = off_q;
    s_d        = s_q;
    done_d     = 1'b0;
    status_d   = status_q;
    res_off_d  = res_off_q;
    res_size_d = res_size_q;
    mreq       = '0;
    mreq.rd_addr = cnt_q;

    case (state_q)
      ST_CLEAR: begin
        mreq.free_we  = 1'b1;
        mreq.free_wa  = cnt_q;
        mreq.free_wd  = (cnt_q == 7'd1);
        mreq.alloc_we = 1'b1;
        mreq.alloc_wa = cnt_q;
        mreq.alloc_wd = 1'b0;
        cnt_d         = cnt_q + 7'd1;
        if (cnt_q == 7'(Depth - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        mreq.rd_addr = free_node;
        if (accept) begin
          if (op_i == OP_ALLOC) begin
            if (dem > 7'(Units)) begin
              done_d     = 1'b1;
              status_d   = STATUS_NO_FIT;
              res_off_d  = 6'd0;
              res_size_d = 3'd0;
            end else begin
              k_d      = ceil_lg(dem);
              cnt_d    = 7'd1;
              best_v_d = 1'b0;
              state_d  = ST_SCAN;
            end
          end else begin
            off_d = free_offset_i;
            s_d   = free_size_log2_i;
            if (free_bad) begin
              done_d     = 1'b1;
              status_d   = STATUS_BAD;
              res_off_d  = free_offset_i;
              res_size_d = free_size_log2_i;
            end else begin
              cur_d   = free_node;
              state_d = ST_FCHK;
            end
          end
        end
      end
      ST_SCAN: begin
        // Issue one node read per cycle; evaluate the node read last cycle.
        if (cnt_q != 7'd0) begin
          chk_v_d = 1'b1;
          chk_n_d = cnt_q;
          cnt_d   = cnt_q + 7'd1;
        end
        if (hit) begin
          best_v_d   = 1'b1;
          best_n_d   = chk_n_q;
          best_off_d = node_off(chk_n_q);
        end
        if (chk_v_q && (chk_n_q == 7'(Depth - 1))) begin
          if (!best_v_d) begin
            done_d     = 1'b1;
            status_d   = STATUS_NO_FIT;
            res_off_d  = 6'd0;
            res_size_d = 3'd0;
            state_d    = ST_IDLE;
          end else begin
            mreq.free_we = 1'b1;
            mreq.free_wa = best_n_d;
            mreq.free_wd = 1'b0;
            cur_d        = best_n_d;
            state_d      = ST_SPLIT;
          end
        end
      end
      ST_SPLIT: begin
        if (node_lvl(cur_q) > k_q) begin
          // Free the upper half, descend into the lower half.
          mreq.free_we = 1'b1;
          mreq.free_wa = {cur_q[NodeW-2:0], 1'b1};
          mreq.free_wd = 1'b1;
          cur_d        = {cur_q[NodeW-2:0], 1'b0};
        end else begin
          mreq.free_we  = 1'b1;
          mreq.free_wa  = cur_q;
          mreq.free_wd  = 1'b0;
          mreq.alloc_we = 1'b1;
          mreq.alloc_wa = cur_q;
          mreq.alloc_wd = 1'b1;
          done_d        = 1'b1;
          status_d      = STATUS_OK;
          res_off_d     = best_off_q;
          res_size_d    = k_q;
          state_d       = ST_IDLE;
        end
      end
      ST_FCHK: begin
        mreq.rd_addr = cur_q ^ 7'd1;
        if (!alloc_rd) begin
          done_d     = 1'b1;
          status_d   = STATUS_BAD;
          res_off_d  = off_q;
          res_size_d = s_q;
          state_d    = ST_IDLE;
        end else begin
          mreq.alloc_we = 1'b1;
          mreq.alloc_wa = cur_q;
          mreq.alloc_wd = 1'b0;
          state_d       = (cur_q == 7'd1) ? ST_FIN : ST_MERGE;
        end
      end
      ST_MERGE: begin
        mreq.rd_addr = nxt ^ 7'd1;
        if (free_rd) begin
          // Absorb the free buddy and climb one level.
          mreq.free_we = 1'b1;
          mreq.free_wa = cur_q ^ 7'd1;
          mreq.free_wd = 1'b0;
          cur_d        = nxt;
          if (nxt == 7'd1) state_d = ST_FIN;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        mreq.free_we = 1'b1;
        mreq.free_wa = cur_q;
        mreq.free_wd = 1'b1;
        done_d       = 1'b1;
        status_d     = STATUS_OK;
        res_off_d    = off_q;
        res_size_d   = s_q;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      cnt_q    <= '0;
      chk_v_q  <= 1'b0;
      best_v_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      chk_v_q  <= chk_v_d;
      best_v_q <= best_v_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_n_q    <= chk_n_d;
    best_n_q   <= best_n_d;
    best_off_q <= best_off_d;
    k_q        <= k_d;
    cur_q      <= cur_d;
    off_q      <= off_d;
    s_q        <= s_d;
    status_q   <= status_d;
    res_off_q  <= res_off_d;
    res_size_q <= res_size_d;
  end

  assign busy_o            = (state_q != ST_IDLE);
  assign done_o            = done_q;
  assign status_o          = status_q;
  assign block_offset_o    = res_off_q;
  assign block_size_log2_o = res_size_q;

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !done_o)
    else $error("result during clearing pass");

  a_grant_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STATUS_OK)) |->
      ((block_offset_o & size_mask(block_size_log2_o)) == 6'd0))
    else $error("granted block not aligned to its size");

  a_split_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SPLIT) |-> (node_lvl(cur_q) >= k_q))
    else $error("split went below demanded size");

  a_merge_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> (cur_q != 7'd1) && (cur_q != 7'd0))
    else $error("merge climbed past root");

endmodule

@@ design/bba_tree.sv @@
module bba_tree (
  input  logic              clk_i,
  input  bba_pkg::mem_req_t req_i,
  output logic              free_rd_o,
  output logic              alloc_rd_o
);
  import bba_pkg::*;

  logic free_mem  [Depth];
  logic alloc_mem [Depth];
  logic free_rd_q;
  logic alloc_rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.free_we) free_mem[req_i.free_wa] <= req_i.free_wd;
    free_rd_q <= free_mem[req_i.rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.alloc_we) alloc_mem[req_i.alloc_wa] <= req_i.alloc_wd;
    alloc_rd_q <= alloc_mem[req_i.rd_addr];
  end

  assign free_rd_o  = free_rd_q;
  assign alloc_rd_o = alloc_rd_q;

endmodule
